// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL. Defining NO_ASSERTIONS
// removes every check.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks an expression at every clock edge outside reset.
`define TLBPC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Checks that a condition is followed by a consequence in the next cycle.
`define TLBPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define TLBPC_ASSERT(lbl, clk, rst_n, prop)
`define TLBPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/tlbpc_pkg.sv =====
// ---------------------------------------------------------------------------
// TLB / page table / cache lookup package
// Sizes, command codes and status codes shared by the lookup core.
// ---------------------------------------------------------------------------
`default_nettype none

package tlbpc_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int PAGE_BITS   = 14;
    localparam int LINE_W      = 32;
    localparam int VA_W        = 16;
    localparam int OFF_W       = 2;
    localparam int BYTE_W      = 8;

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int PAIR_W = 2 * PAGE_BITS;
    localparam int CL_W   = PAGE_BITS + LINE_W;

    // The TLB and the page table share one memory, one half each.
    localparam int PAIR_AW    = IDX_W + 1;
    localparam int PAIR_DEPTH = 2 ** PAIR_AW;

    typedef logic [1:0] t_cmd;
    typedef logic [1:0] t_status;

    localparam t_cmd CMD_LOAD_TLB  = 2'd0;
    localparam t_cmd CMD_LOAD_PAGE = 2'd1;
    localparam t_cmd CMD_LOAD_LINE = 2'd2;
    localparam t_cmd CMD_XLATE     = 2'd3;

    localparam t_status ST_LOADED  = 2'd0;
    localparam t_status ST_FULL    = 2'd1;
    localparam t_status ST_FOUND   = 2'd2;
    localparam t_status ST_UNKNOWN = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/tlbpc_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
`default_nettype none

module tlbpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/tlb_page_table_cache_lookup_core.sv =====
// A load's result goes to a pending register, then to the output register
// once that is free. A translate walks the TLB, then the page table only on
// a TLB miss, then the cache lines, one entry a cycle from each table's memory.
// One item is in flight at a time; the next is taken once the result has
// moved to the output register. Reset empties all three tables at once.
// ---------------------------------------------------------------------------
// TLB, page table and cache lookup core
// Three fill-in-order tables held in two synchronous RAMs, searched by a small
// sequencer for address translation and a byte read from the cache.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tlb_page_table_cache_lookup_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,

    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [1:0]                         i_command,
    input  wire logic [tlbpc_pkg::PAGE_BITS-1:0]    i_entry_key,
    input  wire logic [tlbpc_pkg::PAGE_BITS-1:0]    i_entry_page,
    input  wire logic [tlbpc_pkg::LINE_W-1:0]       i_line_bytes,
    input  wire logic [tlbpc_pkg::VA_W-1:0]         i_virtual_address,

    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [1:0]                              o_status,
    output logic [tlbpc_pkg::BYTE_W-1:0]            o_data_byte
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_TLB  = 3'd1;
    localparam logic [2:0] ST_PT   = 3'd2;
    localparam logic [2:0] ST_LINE = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam int PB = tlbpc_pkg::PAGE_BITS;
    localparam int CW = tlbpc_pkg::CNT_W;
    localparam int IW = tlbpc_pkg::IDX_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(tlbpc_pkg::TABLE_DEPTH);

    logic [2:0]                      r_state, n_state;
    logic [CW-1:0]                   r_tlb_used, n_tlb_used;
    logic [CW-1:0]                   r_page_used, n_page_used;
    logic [CW-1:0]                   r_line_used, n_line_used;
    logic [CW-1:0]                   r_issue, n_issue;
    logic                            r_chk, n_chk;
    logic [PB-1:0]                   r_key, n_key;
    logic [tlbpc_pkg::OFF_W-1:0]     r_off, n_off;
    tlbpc_pkg::t_status              r_pend_status, n_pend_status;
    logic [tlbpc_pkg::BYTE_W-1:0]    r_pend_data, n_pend_data;
    logic                            r_out_valid, n_out_valid;
    tlbpc_pkg::t_status              r_out_status, n_out_status;
    logic [tlbpc_pkg::BYTE_W-1:0]    r_out_data, n_out_data;

    logic                            in_acc;
    logic                            tlb_full, page_full, line_full;
    logic                            tlb_we, page_we, line_we;
    logic                            pair_we;
    logic [tlbpc_pkg::PAIR_AW-1:0]   pair_waddr, pair_raddr;
    logic [tlbpc_pkg::PAIR_W-1:0]    pair_q;
    logic [tlbpc_pkg::CL_W-1:0]      line_q;
    logic [CW-1:0]                   scan_used;
    logic [PB-1:0]                   scan_tag;
    logic                            hit, all_issued;
    logic [tlbpc_pkg::LINE_W-1:0]    line_word;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign tlb_full  = (r_tlb_used == FULL_CNT);
    assign page_full = (r_page_used == FULL_CNT);
    assign line_full = (r_line_used == FULL_CNT);

    assign tlb_we  = in_acc && (i_command == tlbpc_pkg::CMD_LOAD_TLB) && !tlb_full;
    assign page_we = in_acc && (i_command == tlbpc_pkg::CMD_LOAD_PAGE) && !page_full;
    assign line_we = in_acc && (i_command == tlbpc_pkg::CMD_LOAD_LINE) && !line_full;

    // TLB entries live in the lower half of the pair memory and page table
    // entries in the upper half; a load writes only one of them.
    assign pair_we    = tlb_we || page_we;
    assign pair_waddr = page_we ? {1'b1, r_page_used[IW-1:0]} : {1'b0, r_tlb_used[IW-1:0]};
    assign pair_raddr = {(r_state == ST_PT), r_issue[IW-1:0]};

    // Writes happen only in idle and reads only during a walk, so the
    // one-item-at-a-time sequencing is the interlock between them.
    tlbpc_ram #(.WIDTH(tlbpc_pkg::PAIR_W), .DEPTH(tlbpc_pkg::PAIR_DEPTH)) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (pair_we),
        .i_waddr (pair_waddr),
        .i_wdata ({i_entry_key, i_entry_page}),
        .i_raddr (pair_raddr),
        .o_rdata (pair_q)
    );

    tlbpc_ram #(.WIDTH(tlbpc_pkg::CL_W), .DEPTH(tlbpc_pkg::TABLE_DEPTH)) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (r_line_used[IW-1:0]),
        .i_wdata ({i_entry_key, i_line_bytes}),
        .i_raddr (r_issue[IW-1:0]),
        .o_rdata (line_q)
    );

    always_comb begin
        unique case (r_state)
            ST_TLB: begin
                scan_used = r_tlb_used;
                scan_tag  = pair_q[tlbpc_pkg::PAIR_W-1 -: PB];
            end
            ST_PT: begin
                scan_used = r_page_used;
                scan_tag  = pair_q[tlbpc_pkg::PAIR_W-1 -: PB];
            end
            ST_LINE: begin
                scan_used = r_line_used;
                scan_tag  = line_q[tlbpc_pkg::CL_W-1 -: PB];
            end
            default: begin
                scan_used = '0;
                scan_tag  = '0;
            end
        endcase
    end

    // The read data of this cycle belongs to the entry issued last cycle.
    assign hit        = r_chk && (scan_tag == r_key);
    assign all_issued = (r_issue == scan_used);
    assign line_word  = line_q[tlbpc_pkg::LINE_W-1:0];

    always_comb begin
        n_state       = r_state;
        n_tlb_used    = r_tlb_used;
        n_page_used   = r_page_used;
        n_line_used   = r_line_used;
        n_issue       = r_issue;
        n_chk         = r_chk;
        n_key         = r_key;
        n_off         = r_off;
        n_pend_status = r_pend_status;
        n_pend_data   = r_pend_data;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_status  = r_out_status;
        n_out_data    = r_out_data;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_pend_data = '0;
                    n_issue     = '0;
                    n_chk       = 1'b0;
                    unique case (i_command)
                        tlbpc_pkg::CMD_LOAD_TLB: begin
                            n_pend_status = tlb_full ? tlbpc_pkg::ST_FULL
                                                     : tlbpc_pkg::ST_LOADED;
                            if (!tlb_full) begin
                                n_tlb_used = r_tlb_used + CW'(1);
                            end
                            n_state = ST_DONE;
                        end
                        tlbpc_pkg::CMD_LOAD_PAGE: begin
                            n_pend_status = page_full ? tlbpc_pkg::ST_FULL
                                                      : tlbpc_pkg::ST_LOADED;
                            if (!page_full) begin
                                n_page_used = r_page_used + CW'(1);
                            end
                            n_state = ST_DONE;
                        end
                        tlbpc_pkg::CMD_LOAD_LINE: begin
                            n_pend_status = line_full ? tlbpc_pkg::ST_FULL
                                                      : tlbpc_pkg::ST_LOADED;
                            if (!line_full) begin
                                n_line_used = r_line_used + CW'(1);
                            end
                            n_state = ST_DONE;
                        end
                        tlbpc_pkg::CMD_XLATE: begin
                            n_key   = i_virtual_address[tlbpc_pkg::OFF_W +: PB];
                            n_off   = i_virtual_address[tlbpc_pkg::OFF_W-1:0];
                            n_state = ST_TLB;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_TLB, ST_PT, ST_LINE: begin
                if (hit) begin
                    n_issue = '0;
                    n_chk   = 1'b0;
                    if (r_state == ST_TLB) begin
                        n_key   = pair_q[PB-1:0];
                        n_state = ST_LINE;
                    end else if (r_state == ST_PT) begin
                        n_key   = pair_q[PB-1:0];
                        n_state = ST_LINE;
                    end else begin
                        n_pend_status = tlbpc_pkg::ST_FOUND;
                        n_pend_data   = line_word[{r_off, 3'b000} +: tlbpc_pkg::BYTE_W];
                        n_state       = ST_DONE;
                    end
                end else if (all_issued) begin
                    n_issue = '0;
                    n_chk   = 1'b0;
                    if (r_state == ST_TLB) begin
                        n_state = ST_PT;
                    end else begin
                        n_pend_status = tlbpc_pkg::ST_UNKNOWN;
                        n_pend_data   = '0;
                        n_state       = ST_DONE;
                    end
                end else begin
                    n_issue = r_issue + CW'(1);
                    n_chk   = 1'b1;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_pend_status;
                    n_out_data   = r_pend_data;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tlb_used  <= '0;
            r_page_used <= '0;
            r_line_used <= '0;
            r_issue     <= '0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tlb_used  <= n_tlb_used;
            r_page_used <= n_page_used;
            r_line_used <= n_line_used;
            r_issue     <= n_issue;
            r_chk       <= n_chk;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key         <= n_key;
        r_off         <= n_off;
        r_pend_status <= n_pend_status;
        r_pend_data   <= n_pend_data;
        r_out_status  <= n_out_status;
        r_out_data    <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_data_byte = r_out_data;

    `TLBPC_ASSERT(a_counts_bounded, i_clk, i_rst_n, (r_tlb_used <= FULL_CNT) && (r_page_used <= FULL_CNT) && (r_line_used <= FULL_CNT))
    `TLBPC_ASSERT(a_issue_in_range, i_clk, i_rst_n, (r_issue <= scan_used) || (r_state == ST_IDLE) || (r_state == ST_DONE))
    `TLBPC_ASSERT_NEXT(a_full_load_keeps_count, i_clk, i_rst_n, in_acc && (i_command == tlbpc_pkg::CMD_LOAD_TLB) && tlb_full, $stable(r_tlb_used) && (r_pend_status == tlbpc_pkg::ST_FULL))
    `TLBPC_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, in_acc, r_state != ST_IDLE)

endmodule

`default_nettype wire
